@@ hdl/bspline_basis_eval_assert.svh @@
// Assertion macros for the B-spline basis evaluator.
// Each macro takes a label, an antecedent and a consequent.
`ifndef BSPLINE_BASIS_EVAL_ASSERT_SVH
`define BSPLINE_BASIS_EVAL_ASSERT_SVH
`ifndef SYNTH
`define BBE_ASSERT_SAME(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("bspline_basis_eval: same-cycle check failed");
`define BBE_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("bspline_basis_eval: next-cycle check failed");
`else
`define BBE_ASSERT_SAME(lbl, a, c)
`define BBE_ASSERT_NEXT(lbl, a, c)
`endif
`endif

@@ hdl/bbe_pkg.sv @@
package bbe_pkg;

   localparam int Q_W = 17;
   localparam logic [Q_W-1:0] Q_ONE = 17'h10000;
   localparam int DVD_W = 33;
   localparam int ORDER_W = 4;
   localparam int INDEX_W = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_ORDER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_CONTROL_INDEX = 1'b1;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;
   localparam logic [INDEX_W-1:0] LAST_INDEX_RESET = 5'd7;
   localparam int DEF_MAX_POINTS = 32;
   localparam int DEF_MAX_ORDER = 8;

   typedef struct packed {
      logic load;
      logic knot_div;
      logic knot_cap;
      logic build;
      logic lvl_init;
      logic rd0;
      logic rd1;
      logic rd2;
      logic t1_start;
      logic t1_cap;
      logic t2_start;
      logic t2_cap;
      logic wr;
      logic out_init;
      logic out_rd;
      logic out_load;
      logic out_next;
   } bbe_cmd_type;

   typedef struct packed {
      logic div_done;
      logic build_last;
      logic k_one;
      logic term1_zero;
      logic term2_zero;
      logic j_last;
      logic i_last;
      logic out_last;
      logic rsp_fire;
   } bbe_stat_type;

endpackage

@@ hdl/bbe_div.sv @@
module bbe_div
   import bbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [Q_W-1:0]   divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [Q_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [Q_W-1:0]   rem_ff;
   logic [Q_W-1:0]   div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [Q_W:0]     trial;
   logic [Q_W:0]     trial_sub;
   logic             take;
   logic [Q_W-1:0]   rem_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, div_ff};
      take = trial >= {1'b0, div_ff};
      rem_in = take ? trial_sub[Q_W-1:0] : trial[Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNT_W'(DVD_W);
            dvd_ff <= dividend;
            div_ff <= divisor;
            rem_ff <= '0;
            quo_ff <= '0;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
            quo_ff <= {quo_ff[DVD_W-2:0], take};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/bbe_ctrl.sv @@
module bbe_ctrl
   import bbe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  bbe_stat_type stat,
   output bbe_cmd_type  cmd,
   output logic         req_stall
);

   typedef enum logic [4:0] {
      S_IDLE, S_KDIV, S_KWAIT, S_BUILD, S_LINIT, S_RD0, S_RD1, S_RD2,
      S_T1, S_T1W, S_T2, S_T2W, S_WR, S_OINIT, S_ORD, S_OLD, S_OWAIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_KDIV;
            end
         end
         S_KDIV: begin
            cmd.knot_div = 1'b1;
            state_in = S_KWAIT;
         end
         S_KWAIT: begin
            if (stat.div_done) begin
               cmd.knot_cap = 1'b1;
               state_in = S_BUILD;
            end
         end
         S_BUILD: begin
            cmd.build = 1'b1;
            if (stat.build_last) state_in = S_LINIT;
         end
         S_LINIT: begin
            if (stat.k_one) begin
               state_in = S_OINIT;
            end else begin
               cmd.lvl_init = 1'b1;
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            cmd.rd0 = 1'b1;
            state_in = S_RD1;
         end
         S_RD1: begin
            cmd.rd1 = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd2 = 1'b1;
            state_in = S_T1;
         end
         S_T1: begin
            if (stat.term1_zero) begin
               state_in = S_T2;
            end else begin
               cmd.t1_start = 1'b1;
               state_in = S_T1W;
            end
         end
         S_T1W: begin
            if (stat.div_done) begin
               cmd.t1_cap = 1'b1;
               state_in = S_T2;
            end
         end
         S_T2: begin
            if (stat.term2_zero) begin
               state_in = S_WR;
            end else begin
               cmd.t2_start = 1'b1;
               state_in = S_T2W;
            end
         end
         S_T2W: begin
            if (stat.div_done) begin
               cmd.t2_cap = 1'b1;
               state_in = S_WR;
            end
         end
         S_WR: begin
            cmd.wr = 1'b1;
            state_in = (stat.j_last && stat.i_last) ? S_OINIT : S_RD0;
         end
         S_OINIT: begin
            cmd.out_init = 1'b1;
            state_in = S_ORD;
         end
         S_ORD: begin
            cmd.out_rd = 1'b1;
            state_in = S_OLD;
         end
         S_OLD: begin
            cmd.out_load = 1'b1;
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            if (stat.rsp_fire) begin
               if (stat.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

@@ hdl/bbe_datapath.sv @@
module bbe_datapath
   import bbe_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int MAX_ORDER = DEF_MAX_ORDER
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bbe_cmd_type           cmd,
   output bbe_stat_type          stat,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [Q_W-1:0]        req_param_u,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [Q_W-1:0]        rsp_weight,
   output logic [INDEX_W-1:0]    rsp_point_index,
   output logic                  rsp_last_weight
);

   localparam int DEPTH = MAX_POINTS + MAX_ORDER;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CW = IDX_W + 1;

   logic [ORDER_W-1:0] order_ff;
   logic [INDEX_W-1:0] last_ff;
   logic [CW-1:0]      k_calc;
   logic [CW-1:0]      n_calc;

   logic [Q_W-1:0] u_ff;
   logic [CW-1:0]  k_ff;
   logic [CW-1:0]  n_ff;
   logic [CW-1:0]  p;
   logic [CW-1:0]  x_ff;
   logic [CW-1:0]  i_ff;
   logic [CW-1:0]  j_ff;
   logic           found_ff;
   logic [Q_W-1:0] q_ff;
   logic [CW-1:0]  r_ff;
   logic [Q_W-1:0] q0_ff;
   logic [CW-1:0]  r0_ff;

   logic [Q_W-1:0] kj_ff, kij_ff, bj_ff, kj1_ff, kij1_ff, bj1_ff;
   logic [DVD_W-1:0] term1_ff, term2_ff;

   logic [Q_W-1:0] knot_mem [DEPTH];
   logic [Q_W-1:0] basis_mem [DEPTH];
   logic [Q_W-1:0] knot_rda_ff, knot_rdb_ff, basis_rd_ff;

   logic             rsp_valid_ff;
   logic [Q_W-1:0]   rsp_weight_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic             rsp_last_ff;

   logic [CW:0]     r_sum;
   logic            wrap;
   logic [Q_W-1:0]  q_step;
   logic [CW-1:0]   r_in;
   logic            interior;
   logic [Q_W-1:0]  knot_val;
   logic            hit;

   logic [CW-1:0]   ra_a, ra_b, ra_basis;
   logic            basis_we;
   logic [IDX_W-1:0] basis_wa;
   logic [Q_W-1:0]  basis_wd;

   logic [Q_W-1:0]  diff1, diff2, d1, d2, den1, den2;
   logic [Q_W-1:0]  mul_a, mul_b;
   logic [DVD_W-1:0] product;
   logic             div_start;
   logic [DVD_W-1:0] div_dividend;
   logic [Q_W-1:0]   div_divisor;
   logic             div_done;
   logic [DVD_W-1:0] div_quo;
   logic [Q_W-1:0]   div_rem;
   logic [DVD_W:0]   sum;
   logic [Q_W-1:0]   sat;
   logic             rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         last_ff <= LAST_INDEX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CURVE_ORDER:        order_ff <= csr_write_data[ORDER_W-1:0];
            CSR_LAST_CONTROL_INDEX: last_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      int kv;
      int nv;
      nv = int'(last_ff);
      if (nv > MAX_POINTS - 1) nv = MAX_POINTS - 1;
      kv = int'(order_ff);
      if (kv == 0) kv = 1;
      if (kv > MAX_ORDER) kv = MAX_ORDER;
      if (kv > nv + 1) kv = nv + 1;
      k_calc = CW'(kv);
      n_calc = CW'(nv);
   end

   always_comb begin
      p = n_ff - k_ff + CW'(2);
      r_sum = {1'b0, r_ff} + {1'b0, r0_ff};
      wrap = r_sum >= {1'b0, p};
      q_step = q_ff + q0_ff + Q_W'(wrap);
      r_in = wrap ? CW'(r_sum - {1'b0, p}) : CW'(r_sum);
      interior = (x_ff >= k_ff) && (x_ff <= n_ff);
      if (x_ff < k_ff) begin
         knot_val = '0;
      end else if (x_ff <= n_ff) begin
         knot_val = q_step;
      end else begin
         knot_val = Q_ONE;
      end
      hit = (x_ff >= k_ff) && (u_ff < knot_val) && !found_ff;
   end

   always_comb begin
      diff1 = u_ff - kj_ff;
      diff2 = kij1_ff - u_ff;
      d1 = kij_ff - kj_ff;
      d2 = kij1_ff - kj1_ff;
      den1 = (d1 == '0) ? Q_ONE : d1;
      den2 = (d2 == '0) ? Q_ONE : d2;
      mul_a = cmd.t2_start ? diff2 : diff1;
      mul_b = cmd.t2_start ? bj1_ff : bj_ff;
      product = DVD_W'(mul_a) * DVD_W'(mul_b);
      div_start = cmd.knot_div | cmd.t1_start | cmd.t2_start;
      if (cmd.knot_div) begin
         div_dividend = DVD_W'(Q_ONE);
         div_divisor = Q_W'(p);
      end else begin
         div_dividend = product;
         div_divisor = cmd.t2_start ? den2 : den1;
      end
      sum = {1'b0, term1_ff} + {1'b0, term2_ff};
      sat = (sum > (DVD_W + 1)'(Q_ONE)) ? Q_ONE : sum[Q_W-1:0];
   end

   bbe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      ra_a = cmd.rd1 ? (j_ff + CW'(1)) : j_ff;
      ra_b = cmd.rd1 ? (i_ff + j_ff + CW'(1)) : (i_ff + j_ff);
      ra_basis = cmd.rd1 ? (j_ff + CW'(1)) : j_ff;
      basis_we = (cmd.build && (x_ff != '0)) || cmd.wr;
      if (cmd.wr) begin
         basis_wa = j_ff[IDX_W-1:0];
         basis_wd = sat;
      end else begin
         basis_wa = IDX_W'(x_ff - CW'(1));
         basis_wd = hit ? Q_ONE : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build) knot_mem[x_ff[IDX_W-1:0]] <= knot_val;
      if (basis_we) basis_mem[basis_wa] <= basis_wd;
      if (cmd.rd0 || cmd.rd1) begin
         knot_rda_ff <= knot_mem[ra_a[IDX_W-1:0]];
         knot_rdb_ff <= knot_mem[ra_b[IDX_W-1:0]];
      end
      if (cmd.rd0 || cmd.rd1 || cmd.out_rd) begin
         basis_rd_ff <= basis_mem[ra_basis[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         u_ff <= req_param_u;
         k_ff <= k_calc;
         n_ff <= n_calc;
         x_ff <= '0;
         found_ff <= 1'b0;
         q_ff <= '0;
         r_ff <= '0;
      end
      if (cmd.knot_cap) begin
         q0_ff <= div_quo[Q_W-1:0];
         r0_ff <= CW'(div_rem);
      end
      if (cmd.build) begin
         x_ff <= x_ff + CW'(1);
         if (hit) found_ff <= 1'b1;
         if (interior) begin
            q_ff <= q_step;
            r_ff <= r_in;
         end
      end
      if (cmd.lvl_init) begin
         i_ff <= CW'(1);
         j_ff <= k_ff - CW'(2);
      end
      if (cmd.rd1) begin
         kj_ff <= knot_rda_ff;
         kij_ff <= knot_rdb_ff;
         bj_ff <= basis_rd_ff;
      end
      if (cmd.rd2) begin
         kj1_ff <= knot_rda_ff;
         kij1_ff <= knot_rdb_ff;
         bj1_ff <= basis_rd_ff;
         term1_ff <= '0;
         term2_ff <= '0;
      end
      if (cmd.t1_cap) term1_ff <= div_quo;
      if (cmd.t2_cap) term2_ff <= div_quo;
      if (cmd.wr) begin
         if (j_ff == n_ff) begin
            i_ff <= i_ff + CW'(1);
            j_ff <= k_ff - i_ff - CW'(2);
         end else begin
            j_ff <= j_ff + CW'(1);
         end
      end
      if (cmd.out_init) j_ff <= '0;
      if (cmd.out_next) j_ff <= j_ff + CW'(1);
      if (cmd.out_load) begin
         rsp_weight_ff <= basis_rd_ff;
         rsp_index_ff <= INDEX_W'(j_ff);
         rsp_last_ff <= (j_ff == n_ff);
      end
   end

   assign rsp_fire = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.div_done = div_done;
      stat.build_last = (x_ff == n_ff + k_ff);
      stat.k_one = (k_ff == CW'(1));
      stat.term1_zero = (u_ff <= kj_ff) || (bj_ff == '0);
      stat.term2_zero = (kij1_ff <= u_ff) || (bj1_ff == '0);
      stat.j_last = (j_ff == n_ff);
      stat.i_last = (i_ff == k_ff - CW'(1));
      stat.out_last = (j_ff == n_ff);
      stat.rsp_fire = rsp_fire;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_last_weight = rsp_last_ff;

endmodule

@@ hdl/bspline_basis_eval.sv @@
// B-spline basis evaluator on a clamped uniform knot vector over [0,1].
// Write curve_order (index 0) and last_control_index (index 1) through the
// csr_ port while the block is idle; a write takes effect at once.
// A request transfer carries one parameter u in Q1.16. The block then
// emits n+1 response transfers, one weight per control point in index
// order, with rsp_last_weight set on the last one.
// The knot table is rebuilt for every request: one division sets the
// knot step, then one knot is written per cycle, n+k+1 knots in all.
// Each recursion entry reads its operands, then uses the shared
// bit-serial divider for every nonzero term; the recursion visits
// (k-1)(n+2) - k(k-1)/2 entries, at most two divisions each.
// Output reads each weight and holds it until the receiver takes it.
// One request is processed at a time; req_stall is high from the request
// transfer until the last weight is transferred. A stalled response holds
// its value. Reset returns the registers to order 4 and index 7 and
// drops any request in flight.
`include "bspline_basis_eval_assert.svh"
module bspline_basis_eval
   import bbe_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int MAX_ORDER = DEF_MAX_ORDER
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [Q_W-1:0]        req_param_u,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [Q_W-1:0]        rsp_weight,
   output logic [INDEX_W-1:0]    rsp_point_index,
   output logic                  rsp_last_weight
);

   bbe_cmd_type  cmd;
   bbe_stat_type stat;

   bbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   bbe_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_ORDER  (MAX_ORDER)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_param_u      (req_param_u),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight       (rsp_weight),
      .rsp_point_index  (rsp_point_index),
      .rsp_last_weight  (rsp_last_weight)
   );

   `BBE_ASSERT_SAME(a_busy_while_rsp, rsp_valid, req_stall)
   `BBE_ASSERT_NEXT(a_last_ends_run, rsp_valid && !rsp_stall && rsp_last_weight, !rsp_valid)
   `BBE_ASSERT_NEXT(a_req_starts_run, req_valid && !req_stall, req_stall && !rsp_valid)

endmodule
